// ----- hw/rtl/kcc_pkg.sv -----
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared constants, codes and helpers for the key collation comparator.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int MAX_KEY_BYTES = 4096;
  localparam int LEN_W         = $clog2(MAX_KEY_BYTES + 1);

  localparam logic [LEN_W:0] MAX_LEN_EXT = (LEN_W + 1)'(MAX_KEY_BYTES);

  // collation rule codes
  localparam logic [4:0] RULE_BINARY = 5'h00;
  localparam logic [4:0] RULE_ULONG  = 5'h10;
  localparam logic [4:0] RULE_HASH   = 5'h12;
  localparam logic [4:0] RULE_ULONGS = 5'h13;

  // order / verdict codes (two's complement, 0 = undecided or equal)
  localparam logic [1:0] ORD_EQUAL  = 2'b00;
  localparam logic [1:0] ORD_AFTER  = 2'b01;
  localparam logic [1:0] ORD_BEFORE = 2'b11;

  localparam logic [2:0] CHUNK_BYTES = 3'd4;

  function automatic logic [2:0] clamp_count(input logic [2:0] n);
    return (n > CHUNK_BYTES) ? CHUNK_BYTES : n;
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'h0000_00FF;
      3'd2: m = 32'h0000_FFFF;
      3'd3: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic is_word_rule(input logic [4:0] r);
    return (r == RULE_ULONG) || (r == RULE_HASH) || (r == RULE_ULONGS);
  endfunction

endpackage

// ----- hw/rtl/key_collation_comparator_unit.sv -----
// ----------------------------------------------------------------------------
// key_collation_comparator_unit
// Streams two index keys side by side and reports their collation order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one chunk pair per word: four
//   bytes of each key, a byte count for each, and final_req on the last pair.
//   Output channel (out_valid/out_ready) carries one word per key pair,
//   produced only for the final chunk pair: order (-1/0/1) and fault.
//   cfg_wr_en/cfg_wr_data write the collation rule; write it while idle.
//   Path: a final word goes through the input register, then the result
//   register, which holds order and fault.
//   Throughput: one word per cycle when no final word stalls; the compare
//   and sticky verdict/length update run between the input and result registers.
//   Stall: while a result waits, non-final words keep flowing; a final word
//   holds in the input register until the result register frees, and
//   in_ready drops only then.
//   Reset: clears rule to binary, the verdict, lengths, overflow and both
//   valid flags.
// ----------------------------------------------------------------------------
module key_collation_comparator_unit import kcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] chunk_a,
  input  logic [2:0]  count_a,
  input  logic [31:0] chunk_b,
  input  logic [2:0]  count_b,
  input  logic        final_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  order,
  output logic        fault
);

  logic [4:0]       rule;
  logic             s1_valid;
  logic [31:0]      s1_chunk_a;
  logic [2:0]       s1_count_a;
  logic [31:0]      s1_chunk_b;
  logic [2:0]       s1_count_b;
  logic             s1_final;

  logic [1:0]       verdict;
  logic [LEN_W-1:0] length_a;
  logic [LEN_W-1:0] length_b;
  logic             overflow;

  logic [1:0]       step_verdict;
  logic [1:0]       verdict_next;
  logic [LEN_W:0]   sum_a;
  logic [LEN_W:0]   sum_b;
  logic             ovf_a;
  logic             ovf_b;
  logic [LEN_W-1:0] length_a_next;
  logic [LEN_W-1:0] length_b_next;
  logic             overflow_next;
  logic             advance;
  logic [1:0]       res_order;
  logic             res_fault;

  kcc_chunk_cmp u_cmp (
    .rule         (rule),
    .chunk_a      (s1_chunk_a),
    .count_a      (s1_count_a),
    .chunk_b      (s1_chunk_b),
    .count_b      (s1_count_b),
    .step_verdict (step_verdict)
  );

  // a non-final word never needs the result register
  assign advance  = s1_valid && (!s1_final || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign verdict_next  = (verdict == ORD_EQUAL) ? step_verdict : verdict;
  assign sum_a         = {1'b0, length_a} + (LEN_W + 1)'(s1_count_a);
  assign sum_b         = {1'b0, length_b} + (LEN_W + 1)'(s1_count_b);
  assign ovf_a         = sum_a > MAX_LEN_EXT;
  assign ovf_b         = sum_b > MAX_LEN_EXT;
  assign length_a_next = ovf_a ? MAX_LEN_EXT[LEN_W-1:0] : sum_a[LEN_W-1:0];
  assign length_b_next = ovf_b ? MAX_LEN_EXT[LEN_W-1:0] : sum_b[LEN_W-1:0];
  assign overflow_next = overflow || ovf_a || ovf_b;

  always_comb begin
    res_order = ORD_EQUAL;
    res_fault = 1'b0;
    if (overflow_next) begin
      res_fault = 1'b1;
    end else begin
      case (rule)
        RULE_BINARY: begin
          res_order = verdict_next;
          if (verdict_next == ORD_EQUAL && length_a_next != length_b_next) begin
            res_order = (length_a_next < length_b_next) ? ORD_BEFORE : ORD_AFTER;
          end
        end
        RULE_ULONG: begin
          if (length_a_next != LEN_W'(4) || length_b_next != LEN_W'(4)) begin
            res_fault = 1'b1;
          end else begin
            res_order = verdict_next;
          end
        end
        RULE_HASH: begin
          if (length_a_next != LEN_W'(8) || length_b_next != LEN_W'(8)) begin
            res_fault = 1'b1;
          end else begin
            res_order = verdict_next;
          end
        end
        RULE_ULONGS: begin
          if (length_a_next != length_b_next || length_a_next == '0 ||
              (length_a_next & LEN_W'(3)) != '0) begin
            res_fault = 1'b1;
          end else begin
            res_order = verdict_next;
          end
        end
        default: begin
          res_fault = 1'b1;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rule      <= RULE_BINARY;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      verdict   <= ORD_EQUAL;
      length_a  <= '0;
      length_b  <= '0;
      overflow  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rule <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        if (s1_final) begin
          verdict  <= ORD_EQUAL;
          length_a <= '0;
          length_b <= '0;
          overflow <= 1'b0;
        end else begin
          verdict  <= verdict_next;
          length_a <= length_a_next;
          length_b <= length_b_next;
          overflow <= overflow_next;
        end
      end
      if (advance && s1_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_chunk_a <= chunk_a;
      s1_count_a <= clamp_count(count_a);
      s1_chunk_b <= chunk_b;
      s1_count_b <= clamp_count(count_b);
      s1_final   <= final_req;
    end
    if (advance && s1_final) begin
      order <= res_order;
      fault <= res_fault;
    end
  end

endmodule

// ----- hw/rtl/kcc_chunk_cmp.sv -----
// ----------------------------------------------------------------------------
// kcc_chunk_cmp
// Compares one chunk pair under the current rule and gives its local verdict.
// ----------------------------------------------------------------------------
module kcc_chunk_cmp import kcc_pkg::*; (
  input  logic [4:0]  rule,
  input  logic [31:0] chunk_a,
  input  logic [2:0]  count_a,
  input  logic [31:0] chunk_b,
  input  logic [2:0]  count_b,
  output logic [1:0]  step_verdict
);

  logic [2:0]  min_count;
  logic [31:0] word_a;
  logic [31:0] word_b;

  assign min_count = (count_a < count_b) ? count_a : count_b;
  assign word_a    = chunk_a & byte_mask(count_a);
  assign word_b    = chunk_b & byte_mask(count_b);

  always_comb begin
    step_verdict = ORD_EQUAL;
    if (rule == RULE_BINARY) begin
      // walk high to low so the lowest differing byte wins
      for (int j = 3; j >= 0; j--) begin
        if (3'(j) < min_count && chunk_a[8*j +: 8] != chunk_b[8*j +: 8]) begin
          step_verdict = (chunk_a[8*j +: 8] < chunk_b[8*j +: 8]) ? ORD_BEFORE : ORD_AFTER;
        end
      end
    end else if (is_word_rule(rule) && count_a != 3'd0 && count_b != 3'd0) begin
      if (word_a != word_b) begin
        step_verdict = (word_a < word_b) ? ORD_BEFORE : ORD_AFTER;
      end
    end
  end

endmodule

// ----- hw/rtl/kcc_checker.sv -----
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks for the key collation comparator, bound to the top level.
// ----------------------------------------------------------------------------
module kcc_checker import kcc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] order,
  input logic       fault
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(order) && $stable(fault))
    else $error("kcc: stalled result changed");

  a_fault_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> order == ORD_EQUAL)
    else $error("kcc: fault with nonzero order");

  a_order_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> order == ORD_EQUAL || order == ORD_AFTER || order == ORD_BEFORE)
    else $error("kcc: bad order code");

  // input backs up only behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("kcc: input stalled without output backpressure");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("kcc: result valid after reset");

endmodule

bind key_collation_comparator_unit kcc_checker u_kcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .order     (order),
  .fault     (fault)
);

// ----- tb/key_collation_comparator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_collation_comparator_unit_tb
// Streams key pairs through the comparator under every collation rule and
// checks each order/fault word against an in-bench collation predictor.
// Random idle and backpressure bursts run on both channels.
// ----------------------------------------------------------------------------
module key_collation_comparator_unit_tb;
  import kcc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int QUIET_TAIL    = 300;
  localparam int DRAIN_CYCLES  = 4;

  typedef struct packed {
    logic [1:0] order;
    logic       fault;
  } collation_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] chunk_a = '0;
  logic [2:0]  count_a = '0;
  logic [31:0] chunk_b = '0;
  logic [2:0]  count_b = '0;
  logic        final_req = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  order;
  logic        fault;

  // predictor state
  logic [4:0]  key_rule = RULE_BINARY;
  logic [1:0]  cmp_verdict = ORD_EQUAL;
  int          len_a = 0;
  int          len_b = 0;
  bit          len_ovf = 1'b0;

  collation_result_t pending_verdicts[$];
  logic [7:0]        key_a_bytes[$];
  logic [7:0]        key_b_bytes[$];

  bit idle_on = 1'b1;
  int items_sent = 0;
  int results_checked = 0;
  int faults_seen = 0;
  int err_count = 0;
  int cycle_count = 0;

  key_collation_comparator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .chunk_a     (chunk_a),
    .count_a     (count_a),
    .chunk_b     (chunk_b),
    .count_b     (count_b),
    .final_req   (final_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .order       (order),
    .fault       (fault)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_collation_comparator_unit_tb: errors");
      $finish;
    end
  end

  // Updates the sticky verdict and lengths for one chunk pair; returns 1 and
  // the order/fault word when the pair closes the keys.
  function automatic bit collate_chunk_pair(input logic [31:0] a, input logic [2:0] na_in,
                                            input logic [31:0] b, input logic [2:0] nb_in,
                                            input logic fin, output collation_result_t res);
    int          na;
    int          nb;
    int          m;
    logic [31:0] keep_a;
    logic [31:0] keep_b;
    na = (na_in > 4) ? 4 : int'(na_in);
    nb = (nb_in > 4) ? 4 : int'(nb_in);
    res = '0;
    if (cmp_verdict == ORD_EQUAL) begin
      if (key_rule == RULE_BINARY) begin
        m = (na < nb) ? na : nb;
        for (int j = 0; j < m; j++) begin
          if (cmp_verdict == ORD_EQUAL && a[8*j +: 8] != b[8*j +: 8])
            cmp_verdict = (a[8*j +: 8] < b[8*j +: 8]) ? ORD_BEFORE : ORD_AFTER;
        end
      end else if ((key_rule == RULE_ULONG || key_rule == RULE_HASH ||
                    key_rule == RULE_ULONGS) && na != 0 && nb != 0) begin
        keep_a = (na == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * na)) - 32'h1);
        keep_b = (nb == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * nb)) - 32'h1);
        if ((a & keep_a) != (b & keep_b))
          cmp_verdict = ((a & keep_a) < (b & keep_b)) ? ORD_BEFORE : ORD_AFTER;
      end
    end
    len_a += na;
    len_b += nb;
    if (len_a > MAX_KEY_BYTES) begin
      len_ovf = 1'b1;
      len_a = MAX_KEY_BYTES;
    end
    if (len_b > MAX_KEY_BYTES) begin
      len_ovf = 1'b1;
      len_b = MAX_KEY_BYTES;
    end
    if (!fin)
      return 1'b0;
    if (len_ovf) begin
      res.fault = 1'b1;
    end else begin
      case (key_rule)
        RULE_BINARY: begin
          res.order = cmp_verdict;
          if (cmp_verdict == ORD_EQUAL && len_a != len_b)
            res.order = (len_a < len_b) ? ORD_BEFORE : ORD_AFTER;
        end
        RULE_ULONG: begin
          if (len_a != 4 || len_b != 4) res.fault = 1'b1;
          else res.order = cmp_verdict;
        end
        RULE_HASH: begin
          if (len_a != 8 || len_b != 8) res.fault = 1'b1;
          else res.order = cmp_verdict;
        end
        RULE_ULONGS: begin
          if (len_a != len_b || len_a == 0 || (len_a % 4) != 0) res.fault = 1'b1;
          else res.order = cmp_verdict;
        end
        default: res.fault = 1'b1;
      endcase
    end
    cmp_verdict = ORD_EQUAL;
    len_a = 0;
    len_b = 0;
    len_ovf = 1'b0;
    return 1'b1;
  endfunction

  // predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    collation_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with nothing expected: order=%0d fault=%0d", $signed(order), fault);
          err_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (want.order !== order) begin
            $error("order: expected %0d, got %0d", $signed(want.order), $signed(order));
            err_count++;
          end
          if (want.fault !== fault) begin
            $error("fault: expected %0d, got %0d", want.fault, fault);
            err_count++;
          end
          results_checked++;
          if (want.fault) faults_seen++;
        end
      end
      if (in_valid && in_ready) begin
        if (collate_chunk_pair(chunk_a, count_a, chunk_b, count_b, final_req, want))
          pending_verdicts.push_back(want);
      end
      if (cfg_wr_en)
        key_rule = cfg_wr_data;
    end
  end

  // result side backpressure
  always begin
    @(negedge clk);
    if (idle_on && !rst && $urandom_range(0, 9) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    out_ready = 1'b1;
  end

  task automatic send_pair(input logic [31:0] a, input logic [2:0] na,
                           input logic [31:0] b, input logic [2:0] nb, input logic fin);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid  = 1'b1;
    chunk_a   = a;
    count_a   = na;
    chunk_b   = b;
    count_b   = nb;
    final_req = fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // rule writes only once all results are out and the pipe has drained
  task automatic set_rule(input logic [4:0] r);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = r;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic make_key_pair(input int la, input int lb, input bit mutate);
    int shared;
    key_a_bytes.delete();
    key_b_bytes.delete();
    for (int i = 0; i < la; i++) key_a_bytes.push_back(8'($urandom));
    for (int i = 0; i < lb; i++)
      key_b_bytes.push_back((i < la) ? key_a_bytes[i] : 8'($urandom));
    shared = (la < lb) ? la : lb;
    if (mutate && shared > 0)
      key_b_bytes[$urandom_range(0, shared - 1)] = 8'($urandom);
  endtask

  // streams key_a_bytes/key_b_bytes; bytes past a count are junk
  task automatic send_key();
    int          la;
    int          lb;
    int          n;
    int          ca;
    int          cb;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [2:0]  fa;
    logic [2:0]  fb;
    la = key_a_bytes.size();
    lb = key_b_bytes.size();
    n  = (((la > lb) ? la : lb) + 3) / 4;
    if (n == 0) n = 1;
    for (int i = 0; i < n; i++) begin
      wa = $urandom;
      wb = $urandom;
      ca = la - 4 * i;
      cb = lb - 4 * i;
      ca = (ca < 0) ? 0 : ((ca > 4) ? 4 : ca);
      cb = (cb < 0) ? 0 : ((cb > 4) ? 4 : cb);
      for (int k = 0; k < 4; k++) begin
        if (k < ca) wa[8*k +: 8] = key_a_bytes[4*i + k];
        if (k < cb) wb[8*k +: 8] = key_b_bytes[4*i + k];
      end
      // full counts sometimes sent as 5..7, which clamp to four
      fa = (ca == 4 && $urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'(ca);
      fb = (cb == 4 && $urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'(cb);
      send_pair(wa, fa, wb, fb, i == n - 1);
    end
  endtask

  task automatic test_binary_order();
    set_rule(RULE_BINARY);
    send_pair(32'h1234_5678, 3'd4, 32'h1234_5678, 3'd4, 1'b1);
    send_pair(32'h0000_0000, 3'd4, 32'hFFFF_FFFF, 3'd4, 1'b1);
    send_pair(32'hFFFF_FFFF, 3'd4, 32'h0000_0000, 3'd4, 1'b1);
    // prefix sorts first
    send_pair(32'hAA33_2211, 3'd3, 32'h4433_2211, 3'd4, 1'b1);
    send_pair(32'h0000_0000, 3'd0, 32'hFFFF_FFFF, 3'd0, 1'b1);
    // short chunk in the middle of the keys
    send_pair(32'h5555_4142, 3'd2, 32'h9999_4142, 3'd4, 1'b0);
    send_pair(32'h0000_0010, 3'd4, 32'h0000_0020, 3'd4, 1'b1);
    send_pair(32'hCAFE_0001, 3'd7, 32'hCAFE_0001, 3'd5, 1'b1);
  endtask

  task automatic test_word_rules();
    set_rule(RULE_ULONG);
    send_pair(32'hFFFF_FFFF, 3'd4, 32'h0000_0001, 3'd4, 1'b1);
    set_rule(RULE_HASH);
    send_pair(32'h0BAD_F00D, 3'd4, 32'h0BAD_F00D, 3'd4, 1'b0);
    send_pair(32'h8000_0000, 3'd4, 32'h7FFF_FFFF, 3'd4, 1'b1);
    set_rule(RULE_ULONGS);
    send_pair(32'h0000_0001, 3'd4, 32'h0000_0001, 3'd4, 1'b0);
    send_pair(32'hFFFF_0000, 3'd4, 32'hFFFF_0000, 3'd4, 1'b0);
    send_pair(32'h1357_9BDF, 3'd4, 32'h1357_9BDF, 3'd4, 1'b1);
  endtask

  task automatic test_length_faults();
    set_rule(RULE_ULONG);
    send_pair(32'h1, 3'd4, 32'h1, 3'd4, 1'b0);
    send_pair(32'h2, 3'd4, 32'h2, 3'd4, 1'b1);
    set_rule(RULE_HASH);
    send_pair(32'h3, 3'd4, 32'h3, 3'd4, 1'b1);
    set_rule(RULE_ULONGS);
    send_pair(32'h4, 3'd4, 32'h4, 3'd4, 1'b0);
    send_pair(32'h5, 3'd0, 32'h5, 3'd4, 1'b1);
    send_pair(32'h6, 3'd0, 32'h6, 3'd0, 1'b1);
    send_pair(32'h7, 3'd4, 32'h7, 3'd4, 1'b0);
    send_pair(32'h8, 3'd2, 32'h8, 3'd2, 1'b1);
  endtask

  task automatic test_unsupported_rules();
    set_rule(5'd1);
    send_pair(32'h0041_0041, 3'd4, 32'h0042_0042, 3'd4, 1'b1);
    set_rule(5'd31);
    send_pair(32'h1111_1111, 3'd4, 32'h1111_1111, 3'd4, 1'b1);
  endtask

  // verdict taken under binary carries into a key closed under the hash rule
  task automatic test_rule_switch_mid_key();
    set_rule(RULE_BINARY);
    send_pair(32'h0000_0101, 3'd4, 32'h0000_0002, 3'd4, 1'b0);
    set_rule(RULE_HASH);
    send_pair(32'hDEAD_BEEF, 3'd4, 32'hDEAD_BEEF, 3'd4, 1'b1);
  endtask

  task automatic test_key_overflow();
    logic [31:0] w;
    set_rule(RULE_BINARY);
    // one byte past the maximum on the first key
    for (int i = 0; i < 1025; i++) begin
      w = $urandom;
      send_pair(w, (i == 1024) ? 3'd1 : 3'd4, w, (i == 1024) ? 3'd0 : 3'd4, i == 1024);
    end
  endtask

  task automatic test_random_keys();
    int          first_item;
    int          keys_on_rule;
    int          la;
    int          lb;
    int          n;
    logic [4:0]  r;
    first_item   = items_sent;
    keys_on_rule = 0;
    r            = RULE_BINARY;
    while (items_sent < first_item + RANDOM_ITEMS) begin
      if (items_sent >= first_item + RANDOM_ITEMS - QUIET_TAIL)
        idle_on = 1'b0;
      if (keys_on_rule == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: r = RULE_BINARY;
          4:          r = RULE_ULONG;
          5:          r = RULE_HASH;
          6, 7:       r = RULE_ULONGS;
          default:    r = 5'($urandom);
        endcase
        set_rule(r);
        keys_on_rule = $urandom_range(5, 30);
      end
      keys_on_rule--;
      if ($urandom_range(0, 9) == 0) begin
        // noise: raw counts, finals anywhere or nowhere
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_pair($urandom, 3'($urandom), $urandom, 3'($urandom),
                    $urandom_range(0, 3) == 0);
      end else begin
        case (r)
          RULE_BINARY: begin
            la = $urandom_range(0, 20);
            lb = ($urandom_range(0, 9) < 7) ? la : $urandom_range(0, 20);
          end
          RULE_ULONG: begin
            la = ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(0, 9);
            lb = ($urandom_range(0, 9) < 8) ? la : $urandom_range(0, 9);
          end
          RULE_HASH: begin
            la = ($urandom_range(0, 9) < 8) ? 8 : $urandom_range(0, 12);
            lb = ($urandom_range(0, 9) < 8) ? la : $urandom_range(0, 12);
          end
          RULE_ULONGS: begin
            la = ($urandom_range(0, 9) < 8) ? 4 * $urandom_range(1, 6) : $urandom_range(0, 24);
            lb = ($urandom_range(0, 9) < 8) ? la : $urandom_range(0, 24);
          end
          default: begin
            la = $urandom_range(0, 12);
            lb = $urandom_range(0, 12);
          end
        endcase
        make_key_pair(la, lb, $urandom_range(0, 9) < 6);
        send_key();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_binary_order();
    test_word_rules();
    test_length_faults();
    test_unsupported_rules();
    test_rule_switch_mid_key();
    test_key_overflow();
    test_random_keys();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d chunk pair words; checked %0d collation results, %0d of them faults",
             items_sent, results_checked, faults_seen);
    $display("rules covered: binary, single word, hash, word array, unsupported codes");
    if (err_count == 0)
      $display("key_collation_comparator_unit_tb: clean");
    else
      $display("key_collation_comparator_unit_tb: errors");
    $finish;
  end

endmodule
